@@ rtl/plw_pkg.sv @@
`default_nettype none

package plw_pkg;

    localparam int POOL_PAGES_DEF = 64;
    localparam int IDX_W          = 9;
    localparam int ENTRY_W        = 64;
    localparam int VA_W           = 48;
    localparam int PA_W           = 52;
    localparam int FLAG_W         = 12;
    localparam int BASE_PG_W      = PA_W - FLAG_W;
    localparam int CFG_IDX_W      = 1;

    localparam logic [1:0] CMD_MAP   = 2'd0;
    localparam logic [1:0] CMD_UNMAP = 2'd1;
    localparam logic [1:0] CMD_XLATE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_PRES = 2'd1;
    localparam logic [1:0] ST_POOL_OUT = 2'd2;
    localparam logic [1:0] ST_PTR_OUT  = 2'd3;

    localparam logic [1:0] LVL_LEAF = 2'd3;
    localparam logic [1:0] LVL_LAST_MID = 2'd2;

    localparam logic [FLAG_W-1:0] DEFAULT_FLAGS = 12'h007;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ACTIVE = 1'd1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [VA_W-1:0]   virt_addr;
        logic [PA_W-1:0]   phys_addr;
        logic [FLAG_W-1:0] page_flags;
    } t_request;

    typedef struct packed {
        logic [ENTRY_W-1:0] translated_address;
        logic [1:0]         status;
        logic               tlb_flush;
        logic [VA_W-1:0]    invalidate_address;
    } t_result;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ rtl/plw_mem.sv @@
`default_nettype none

module plw_mem #(
    parameter int DEPTH  = plw_pkg::POOL_PAGES_DEF * 512,
    parameter int ADDR_W = 15
) (
    input  wire logic                         i_clk,
    input  wire plw_pkg::t_mem_ctl            i_ctl,
    input  wire logic [ADDR_W-1:0]            i_addr,
    input  wire logic [plw_pkg::ENTRY_W-1:0]  i_wr_data,
    output logic      [plw_pkg::ENTRY_W-1:0]  o_rd_data
);

    logic [plw_pkg::ENTRY_W-1:0] r_mem [0:DEPTH-1];
    logic [plw_pkg::ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/plw_ctrl.sv @@
`default_nettype none

module plw_ctrl #(
    parameter int POOL_PAGES = plw_pkg::POOL_PAGES_DEF,
    parameter int ADDR_W     = 15
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire plw_pkg::t_request             i_req,
    input  wire logic [plw_pkg::BASE_PG_W-1:0] i_base_pg,
    input  wire logic                          i_active,
    output logic                               o_busy,
    output logic                               o_valid,
    output plw_pkg::t_result                   o_res,
    output plw_pkg::t_mem_ctl                  o_mem_ctl,
    output logic [ADDR_W-1:0]                  o_mem_addr,
    output logic [plw_pkg::ENTRY_W-1:0]        o_mem_wr_data,
    input  wire logic [plw_pkg::ENTRY_W-1:0]   i_mem_rd_data
);

    localparam int PAGE_W = ADDR_W - plw_pkg::IDX_W;
    localparam int CNT_W  = $clog2(POOL_PAGES + 1);
    localparam int DEPTH  = POOL_PAGES * 512;
    localparam int PGN_W  = plw_pkg::BASE_PG_W + 1;
    localparam int EPG_W  = plw_pkg::ENTRY_W - plw_pkg::FLAG_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_EVAL  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [1:0]           r_level, n_level;
    logic [PAGE_W-1:0]    r_page, n_page;
    logic [CNT_W-1:0]     r_nfree, n_nfree;
    logic [ADDR_W-1:0]    r_clr, n_clr;
    plw_pkg::t_request    r_req, n_req;
    logic                 r_valid, n_valid;
    plw_pkg::t_result     r_res, n_res;

    logic [EPG_W-1:0]             ent_pg;
    logic [EPG_W-1:0]             base_ext;
    logic [EPG_W-1:0]             pg_diff;
    logic                         pg_out;
    logic                         pool_full;
    logic [PGN_W-1:0]             new_pgnum;
    logic [plw_pkg::FLAG_W-1:0]   new_flags;
    logic [plw_pkg::ENTRY_W-1:0]  new_entry;
    logic [plw_pkg::ENTRY_W-1:0]  leaf_entry;

    assign ent_pg    = i_mem_rd_data[plw_pkg::ENTRY_W-1:plw_pkg::FLAG_W];
    assign base_ext  = EPG_W'(i_base_pg);
    assign pg_diff   = ent_pg - base_ext;
    assign pg_out    = (ent_pg < base_ext) || (pg_diff >= EPG_W'(POOL_PAGES));
    assign pool_full = r_nfree >= CNT_W'(POOL_PAGES);
    assign new_pgnum = PGN_W'(i_base_pg) + PGN_W'(r_nfree[PAGE_W-1:0]);
    assign new_flags = (r_req.cmd == plw_pkg::CMD_MAP) ? r_req.page_flags
                                                       : plw_pkg::DEFAULT_FLAGS;
    assign new_entry = {11'b0, new_pgnum, 12'b0}
                     | plw_pkg::ENTRY_W'(new_flags);
    assign leaf_entry = (r_req.cmd == plw_pkg::CMD_MAP)
                      ? (plw_pkg::ENTRY_W'(r_req.phys_addr)
                         | plw_pkg::ENTRY_W'(r_req.page_flags))
                      : '0;

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_page    = r_page;
        n_nfree   = r_nfree;
        n_clr     = r_clr;
        n_req     = r_req;
        n_valid   = 1'b0;
        n_res     = r_res;
        o_mem_ctl = '0;
        o_mem_wr_data = new_entry;
        o_mem_addr = {r_page, plw_pkg::level_index(r_req.virt_addr, r_level)};

        unique case (r_state)
            S_CLEAR: begin
                o_mem_addr    = r_clr;
                o_mem_wr_data = '0;
                o_mem_ctl.wr_en = 1'b1;
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_level = 2'd0;
                    n_page  = '0;
                    if (i_req.cmd == plw_pkg::CMD_MAP || i_req.cmd == plw_pkg::CMD_UNMAP
                        || i_req.cmd == plw_pkg::CMD_XLATE) begin
                        n_state = S_READ;
                    end else begin
                        n_valid = 1'b1;
                        n_res   = '0;
                    end
                end
            end
            S_READ: begin
                o_mem_ctl.rd_en = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_level == plw_pkg::LVL_LEAF) begin
                    n_valid = 1'b1;
                    n_res   = '0;
                    n_state = S_IDLE;
                    if (i_mem_rd_data[0]) begin
                        n_res.translated_address = {ent_pg, 12'b0};
                    end else begin
                        n_res.status = plw_pkg::ST_NOT_PRES;
                    end
                end else if (i_mem_rd_data[0] && pg_out) begin
                    n_valid = 1'b1;
                    n_res   = '0;
                    n_res.status = plw_pkg::ST_PTR_OUT;
                    n_state = S_IDLE;
                end else if (!i_mem_rd_data[0] && pool_full) begin
                    n_valid = 1'b1;
                    n_res   = '0;
                    n_res.status = plw_pkg::ST_POOL_OUT;
                    n_state = S_IDLE;
                end else begin
                    if (i_mem_rd_data[0]) begin
                        n_page = pg_diff[PAGE_W-1:0];
                    end else begin
                        o_mem_ctl.wr_en = 1'b1;
                        n_page  = r_nfree[PAGE_W-1:0];
                        n_nfree = r_nfree + CNT_W'(1);
                    end
                    n_level = r_level + 2'd1;
                    if (r_level == plw_pkg::LVL_LAST_MID
                        && r_req.cmd != plw_pkg::CMD_XLATE) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_WRITE: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_wr_data   = leaf_entry;
                n_valid = 1'b1;
                n_res   = '0;
                n_res.tlb_flush = i_active;
                n_res.invalidate_address = i_active ? r_req.virt_addr : '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_level <= '0;
            r_page  <= '0;
            r_nfree <= CNT_W'(1);
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            r_page  <= n_page;
            r_nfree <= n_nfree;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
        r_req <= n_req;
        r_res <= n_res;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.rd_en && o_mem_ctl.wr_en))
        else $error("store read and write in one cycle");

    a_nfree_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfree <= CNT_W'(POOL_PAGES) && r_nfree != '0)
        else $error("allocator out of range");

    a_read_then_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_state == S_EVAL)
        else $error("read not followed by evaluation");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_IDLE)
        else $error("word strobed while walk in flight");

    a_leaf_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> r_level == plw_pkg::LVL_LEAF
            && r_req.cmd != plw_pkg::CMD_XLATE)
        else $error("leaf write at wrong level");
`endif

endmodule

`default_nettype wire

@@ rtl/four_level_page_table_walker.sv @@
`default_nettype none

// Four-level page table walker over an on-chip pool of POOL_PAGES table
// pages (page 0 is the top level). Pulse start with a request word while
// busy is low; one result word comes back on o_res, strobed by o_valid for
// a single cycle, and cannot be held off. Each table level passes through a read
// state and an evaluate state on the single-port store (registered read data):
// map/unmap end in a leaf write, translate reads the leaf, an unused command is
// answered from idle, and a walk stops early on pool exhaustion or a bad pointer.
// After reset the block stays busy while it zeroes all POOL_PAGES*512 store words
// (32768 by default). Configuration writes are taken at any time.
module four_level_page_table_walker #(
    parameter int POOL_PAGES = plw_pkg::POOL_PAGES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    input  wire plw_pkg::t_request               i_req,
    output logic                                 busy,
    output logic                                 o_valid,
    output plw_pkg::t_result                     o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [plw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [plw_pkg::PA_W-1:0]        i_cfg_data
);

    localparam int PAGE_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int ADDR_W = PAGE_W + plw_pkg::IDX_W;
    localparam int DEPTH  = POOL_PAGES * 512;

    logic [plw_pkg::BASE_PG_W-1:0] r_base_pg;
    logic                          r_active;

    plw_pkg::t_mem_ctl             mem_ctl;
    logic [ADDR_W-1:0]             mem_addr;
    logic [plw_pkg::ENTRY_W-1:0]   mem_wr_data;
    logic [plw_pkg::ENTRY_W-1:0]   mem_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_pg <= '0;
            r_active  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                plw_pkg::CFG_POOL_BASE: begin
                    r_base_pg <= i_cfg_data[plw_pkg::PA_W-1:plw_pkg::FLAG_W];
                end
                plw_pkg::CFG_MAP_ACTIVE: begin
                    r_active <= i_cfg_data[0];
                end
                default: begin
                    r_active <= r_active;
                end
            endcase
        end
    end

    plw_ctrl #(
        .POOL_PAGES (POOL_PAGES),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_req         (i_req),
        .i_base_pg     (r_base_pg),
        .i_active      (r_active),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .o_res         (o_res),
        .o_mem_ctl     (mem_ctl),
        .o_mem_addr    (mem_addr),
        .o_mem_wr_data (mem_wr_data),
        .i_mem_rd_data (mem_rd_data)
    );

    plw_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int RUN_LIMIT = 400000;
    localparam int SETTLE = 16;

    class page_walk_board;
        localparam int STORE_DEPTH = plw_pkg::POOL_PAGES_DEF * 512;

        bit [63:0]        page_store [0:STORE_DEPTH-1];
        int               next_page;
        bit [63:0]        pool_base;
        bit               map_active;
        plw_pkg::t_result want_q[$];
        int               mismatches;

        function new();
            next_page  = 1;
            pool_base  = 64'h0;
            map_active = 1'b1;
            mismatches = 0;
        endfunction

        function void set_reg(logic [plw_pkg::CFG_IDX_W-1:0] idx,
                              logic [plw_pkg::PA_W-1:0] data);
            if (idx == plw_pkg::CFG_POOL_BASE) begin
                pool_base = {12'h000, data[plw_pkg::PA_W-1:12], 12'h000};
            end else if (idx == plw_pkg::CFG_MAP_ACTIVE) begin
                map_active = data[0];
            end
        endfunction

        // descend the three intermediate levels, allocating missing tables
        function logic [1:0] walk_levels(logic [plw_pkg::VA_W-1:0] va,
                                         logic [63:0] new_flags,
                                         output int leaf_slot);
            int        page;
            int        slot;
            bit [63:0] ent;
            bit [63:0] addr;
            bit [63:0] off;
            page = 0;
            leaf_slot = 0;
            for (int lv = 0; lv < 3; lv++) begin
                slot = page * 512 + int'((va >> (39 - 9 * lv)) & 48'h1ff);
                ent = page_store[slot];
                if (ent[0]) begin
                    addr = ent & ~64'hfff;
                    if (addr < pool_base) return plw_pkg::ST_PTR_OUT;
                    off = (addr - pool_base) >> 12;
                    if (off >= 64'(plw_pkg::POOL_PAGES_DEF)) return plw_pkg::ST_PTR_OUT;
                    page = int'(off);
                end else begin
                    if (next_page >= plw_pkg::POOL_PAGES_DEF) return plw_pkg::ST_POOL_OUT;
                    page = next_page;
                    next_page++;
                    page_store[slot] = (pool_base + (64'(page) << 12)) | new_flags;
                end
            end
            leaf_slot = page * 512 + int'(va[20:12]);
            return plw_pkg::ST_OK;
        endfunction

        function void note_request(plw_pkg::t_request r);
            plw_pkg::t_result res;
            int               leaf;
            logic [1:0]       st;
            bit [63:0]        nf;
            bit [63:0]        ent;
            res = '0;
            if (r.cmd != CMD_NONE) begin
                nf = (r.cmd == plw_pkg::CMD_MAP) ? 64'(r.page_flags)
                                                 : 64'(plw_pkg::DEFAULT_FLAGS);
                st = walk_levels(r.virt_addr, nf, leaf);
                if (st != plw_pkg::ST_OK) begin
                    res.status = st;
                end else if (r.cmd == plw_pkg::CMD_XLATE) begin
                    ent = page_store[leaf];
                    if (ent[0]) begin
                        res.translated_address = ent & ~64'hfff;
                    end else begin
                        res.status = plw_pkg::ST_NOT_PRES;
                    end
                end else begin
                    if (r.cmd == plw_pkg::CMD_MAP) begin
                        page_store[leaf] = 64'(r.phys_addr) | 64'(r.page_flags);
                    end else begin
                        page_store[leaf] = 64'h0;
                    end
                    if (map_active) begin
                        res.tlb_flush = 1'b1;
                        res.invalidate_address = r.virt_addr;
                    end
                end
            end
            want_q.push_back(res);
        endfunction

        function void check_result(plw_pkg::t_result got);
            plw_pkg::t_result want;
            if (want_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = want_q.pop_front();
            if (got.translated_address !== want.translated_address ||
                got.status !== want.status ||
                got.tlb_flush !== want.tlb_flush ||
                got.invalidate_address !== want.invalidate_address) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: xlat exp %h got %h, status exp %0d got %0d",
                             want.translated_address, got.translated_address,
                             want.status, got.status);
                    $display("          inval exp %0d got %0d, inval addr exp %h got %h",
                             want.tlb_flush, got.tlb_flush,
                             want.invalidate_address, got.invalidate_address);
                end
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    plw_pkg::t_request             i_req = '0;
    logic                          busy;
    logic                          o_valid;
    plw_pkg::t_result              o_res;
    logic                          i_cfg_we = 1'b0;
    logic [plw_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [plw_pkg::PA_W-1:0]      i_cfg_data = '0;

    page_walk_board board = new();

    logic [8:0]               reg_top [3];
    logic [8:0]               reg_mid [2];
    logic [8:0]               reg_low [2];
    logic [plw_pkg::PA_W-1:0] base_b;
    logic [plw_pkg::PA_W-1:0] junk;

    four_level_page_table_walker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) board.check_result(o_res);
    end

    function automatic plw_pkg::t_request make_req(logic [1:0] cmd,
                                                   logic [plw_pkg::VA_W-1:0] va,
                                                   logic [plw_pkg::PA_W-1:0] pa,
                                                   logic [plw_pkg::FLAG_W-1:0] flags);
        plw_pkg::t_request r;
        r.cmd = cmd;
        r.virt_addr = va;
        r.phys_addr = pa;
        r.page_flags = flags;
        return r;
    endfunction

    // mostly a small fixed set of table paths so the pool lasts
    function automatic logic [plw_pkg::VA_W-1:0] rand_va(bit fresh);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if (fresh) return raw[plw_pkg::VA_W-1:0];
        return {reg_top[$urandom_range(0, 2)], reg_mid[$urandom_range(0, 1)],
                reg_low[$urandom_range(0, 1)], raw[20:0]};
    endfunction

    function automatic plw_pkg::t_request rand_request(int fresh_pct);
        plw_pkg::t_request r;
        int                pick;
        logic [63:0]       raw;
        pick = $urandom_range(0, 99);
        if (pick < 40) r.cmd = plw_pkg::CMD_MAP;
        else if (pick < 55) r.cmd = plw_pkg::CMD_UNMAP;
        else if (pick < 95) r.cmd = plw_pkg::CMD_XLATE;
        else r.cmd = CMD_NONE;
        r.virt_addr = rand_va($urandom_range(0, 99) < fresh_pct);
        raw = {$urandom, $urandom};
        r.phys_addr = raw[plw_pkg::PA_W-1:0];
        r.page_flags = 12'($urandom_range(0, 4095));
        if (r.cmd == plw_pkg::CMD_MAP && $urandom_range(0, 99) < 85) r.page_flags[0] = 1'b1;
        return r;
    endfunction

    task automatic send_req(plw_pkg::t_request r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_request(r);
    endtask

    task automatic run_random(int n, int fresh_pct);
        int burst;
        int gap;
        burst = 0;
        repeat (n) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 10);
            end
            send_req(rand_request(fresh_pct));
            burst--;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [plw_pkg::CFG_IDX_W-1:0] idx,
                             logic [plw_pkg::PA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        foreach (reg_top[i]) reg_top[i] = 9'($urandom);
        foreach (reg_mid[i]) reg_mid[i] = 9'($urandom);
        foreach (reg_low[i]) reg_low[i] = 9'($urandom);
        base_b = {1'b0, 19'($urandom), $urandom};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // store clear pass after reset
        do @(posedge i_clk); while (busy !== 1'b0);

        write_reg(plw_pkg::CFG_POOL_BASE, base_b);
        write_reg(plw_pkg::CFG_MAP_ACTIVE, 52'h1);

        send_req(make_req(plw_pkg::CMD_XLATE, 48'h0, 52'h0, 12'h000));
        send_req(make_req(plw_pkg::CMD_MAP, 48'h0, 52'h0, 12'h001));
        send_req(make_req(plw_pkg::CMD_XLATE, 48'h0, 52'h0, 12'h000));
        send_req(make_req(plw_pkg::CMD_MAP, '1, '1, 12'hfff));
        send_req(make_req(plw_pkg::CMD_XLATE, '1, 52'h0, 12'h000));
        send_req(make_req(plw_pkg::CMD_UNMAP, '1, '1, 12'hfff));
        send_req(make_req(plw_pkg::CMD_XLATE, '1, '1, 12'hfff));
        // intermediates written without valid bit, then reallocated
        send_req(make_req(plw_pkg::CMD_MAP, 48'h5a5a_1234_5678, 52'h9_8765_4321_0abc,
                          12'h006));
        send_req(make_req(plw_pkg::CMD_XLATE, 48'h5a5a_1234_5678, 52'h0, 12'h000));
        send_req(make_req(plw_pkg::CMD_MAP, 48'h5a5a_1234_5678, 52'h9_8765_4321_0abc,
                          12'h000));
        send_req(make_req(plw_pkg::CMD_XLATE, 48'h5a5a_1234_5678, 52'h0, 12'h000));
        send_req(make_req(plw_pkg::CMD_MAP, 48'h5a5a_1234_5678, 52'h9_8765_4321_0abc,
                          12'h001));
        send_req(make_req(plw_pkg::CMD_XLATE, 48'h5a5a_1234_5678, 52'h0, 12'h000));
        send_req(make_req(CMD_NONE, '1, '1, 12'hfff));
        send_req(make_req(CMD_NONE, 48'h0, 52'h0, 12'h000));
        send_req(make_req(plw_pkg::CMD_UNMAP, 48'ha5a5_edcb_a987, '1, 12'h000));
        send_req(make_req(plw_pkg::CMD_XLATE, 48'ha5a5_edcb_a987, 52'h0, 12'h000));
        send_req(make_req(plw_pkg::CMD_MAP, 48'ha5a5_edcb_a987, '1, 12'hffe));
        send_req(make_req(plw_pkg::CMD_XLATE, 48'ha5a5_edcb_a987, 52'h0, 12'h000));
        send_req(make_req(plw_pkg::CMD_MAP, 48'ha5a5_edcb_a987, 52'h0_0000_0000_1000,
                          12'hfff));
        send_req(make_req(plw_pkg::CMD_XLATE, 48'ha5a5_edcb_a987, 52'h0, 12'h000));
        drain();

        run_random(300, 0);
        drain();

        junk = {20'($urandom), $urandom} & ~52'h1;
        write_reg(plw_pkg::CFG_MAP_ACTIVE, junk);
        run_random(120, 2);
        drain();

        // shifted base: old pointers land below the pool or on other pages
        write_reg(plw_pkg::CFG_POOL_BASE, (base_b & ~52'hfff) + 52'h5000);
        junk = {20'($urandom), $urandom} | 52'h1;
        write_reg(plw_pkg::CFG_MAP_ACTIVE, junk);
        run_random(100, 5);
        drain();

        write_reg(plw_pkg::CFG_POOL_BASE, 52'h0);
        write_reg(plw_pkg::CFG_MAP_ACTIVE, 52'($urandom_range(0, 1)));
        run_random(80, 5);
        drain();

        write_reg(plw_pkg::CFG_POOL_BASE, '1);
        run_random(80, 10);
        drain();

        write_reg(plw_pkg::CFG_POOL_BASE, base_b);
        write_reg(plw_pkg::CFG_MAP_ACTIVE, 52'h1);
        run_random(220, 40);
        drain();

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
